/* rtl/fabric_path_record_walker_macros.svh */
// ---------------------------------------------------------------------------
// Path record walker assertion macros
// Shared concurrent check forms, clocked on i_clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef FABRIC_PATH_RECORD_WALKER_MACROS_SVH
`define FABRIC_PATH_RECORD_WALKER_MACROS_SVH

// same-cycle implication
`define FPW_CHECK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("path walker check failed");

// next-cycle implication
`define FPW_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("path walker check failed");

`endif

/* rtl/fpw_pkg.sv */
// ---------------------------------------------------------------------------
// Path record walker package
// Table sizes, payload types, controller/datapath command and status types.
// ---------------------------------------------------------------------------
package fpw_pkg;

    localparam int PORT_ENTRIES   = 256;
    localparam int LINK_ENTRIES   = 256;
    localparam int SWITCH_ENTRIES = 64;
    localparam int BLOCK_ENTRIES  = 256;
    localparam int HOP_LIMIT      = 64;
    localparam int BLOCK_BYTES    = 64;

    localparam int PORT_AW = $clog2(PORT_ENTRIES);
    localparam int LINK_AW = $clog2(LINK_ENTRIES);
    localparam int TOP_AW  = $clog2(SWITCH_ENTRIES);
    localparam int BLK_AW  = $clog2(BLOCK_ENTRIES);
    localparam int POS_W   = $clog2(BLOCK_BYTES);
    localparam int IDX_W   = 9;

    localparam logic [7:0] NO_PATH_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        ACT_PORT_LOAD  = 3'd0,
        ACT_LINK_LOAD  = 3'd1,
        ACT_TOP_LOAD   = 3'd2,
        ACT_BLOCK_LOAD = 3'd3,
        ACT_BYTE_LOAD  = 3'd4,
        ACT_QUERY      = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOPATH = 2'd1,
        ST_ERR    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_PORT_USED   = 2'd0,
        CFG_LINK_USED   = 2'd1,
        CFG_SWITCH_USED = 2'd2,
        CFG_BLOCK_USED  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  slot;
        logic [15:0] first_lid;
        logic [7:0]  first_port;
        logic [15:0] second_lid;
        logic [7:0]  second_port;
        logic        first_is_switch;
        logic        second_is_switch;
        logic [4:0]  link_rate;
        logic [3:0]  port_mtu;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] path_mtu;
        logic [4:0] path_rate;
        logic [6:0] hop_count;
    } t_result;

    typedef enum logic [1:0] {
        TBL_PORT = 2'd0,
        TBL_LINK = 2'd1,
        TBL_TOP  = 2'd2,
        TBL_BLK  = 2'd3
    } t_tbl;

    typedef enum logic [2:0] {
        KEY_SRC = 3'd0,
        KEY_DST = 3'd1,
        KEY_FWD = 3'd2,
        KEY_CUR = 3'd3,
        KEY_TO  = 3'd4
    } t_key;

    typedef struct packed {
        logic    scan_clr;
        logic    scan_inc;
        t_tbl    tbl;
        t_key    key;
        logic    rd_cur;
        logic    cap_sp;
        logic    cap_dp;
        logic    cap_port;
        logic    merge;
        logic    inc_hop;
        logic    cap_link;
        logic    cap_blk;
        logic    cap_out;
        logic    fwd_src;
        logic    fwd_to;
        logic    finish;
        t_status fin_status;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic empty;
        logic idx_is_dp;
        logic port_is_dp;
        logic rd_sw;
        logic top_bad;
        logic byte_nopath;
        logic hop_over;
        logic src_sw;
        logic out_busy;
    } t_stat;

    // position of a rate code in the speed order; unknown codes rank lowest
    function automatic logic [4:0] rate_rank(input logic [4:0] code);
        logic [4:0] rank;
        case (code)
            5'd2:    rank = 5'd1;
            5'd3:    rank = 5'd3;
            5'd4:    rank = 5'd6;
            5'd5:    rank = 5'd2;
            5'd6:    rank = 5'd5;
            5'd7:    rank = 5'd8;
            5'd8:    rank = 5'd9;
            5'd9:    rank = 5'd11;
            5'd10:   rank = 5'd12;
            5'd11:   rank = 5'd4;
            5'd12:   rank = 5'd10;
            5'd13:   rank = 5'd14;
            5'd14:   rank = 5'd15;
            5'd15:   rank = 5'd7;
            5'd16:   rank = 5'd13;
            5'd17:   rank = 5'd16;
            5'd18:   rank = 5'd17;
            default: rank = 5'd0;
        endcase
        return rank;
    endfunction

endpackage

/* rtl/fpw_datapath.sv */
// ---------------------------------------------------------------------------
// Path record walker datapath
// Table memories, scan index, search compare, path accumulators, result reg.
// ---------------------------------------------------------------------------
module fpw_datapath
    import fpw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  t_item          i_item,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [8:0]     i_cfg_data,
    input  t_cmd           i_cmd,
    output t_stat          o_stat,
    input  logic           i_out_stall,
    output logic           o_valid,
    output t_result        o_result
);

    typedef struct packed {
        logic [15:0] lid;
        logic [7:0]  num;
        logic        sw;
        logic [4:0]  rate;
        logic [3:0]  mtu;
    } t_port_ent;

    typedef struct packed {
        logic [15:0] from_lid;
        logic [7:0]  from_port;
        logic [15:0] to_lid;
        logic [7:0]  to_port;
    } t_link_ent;

    typedef struct packed {
        logic [15:0] lid;
        logic [15:0] top;
    } t_top_ent;

    typedef struct packed {
        logic [15:0] lid;
        logic [15:0] num;
    } t_blk_ent;

    t_port_ent port_mem [PORT_ENTRIES];
    t_link_ent link_mem [LINK_ENTRIES];
    t_top_ent  top_mem  [SWITCH_ENTRIES];
    t_blk_ent  blk_mem  [BLOCK_ENTRIES];
    logic [7:0] byte_mem [BLOCK_ENTRIES*BLOCK_BYTES];

    t_port_ent  r_rd_port;
    t_link_ent  r_rd_link;
    t_top_ent   r_rd_top;
    t_blk_ent   r_rd_blk;
    logic [7:0] r_rd_byte;

    logic [8:0] r_port_used, r_link_used, r_blk_used;
    logic [6:0] r_sw_used;

    logic [IDX_W-1:0]   r_idx;
    t_tbl               r_tbl;
    logic [15:0]        r_key_lid;
    logic [7:0]         r_key_pn;
    logic               r_key_host;

    logic [15:0]        r_src, r_dst, r_fwd_lid, r_to_lid;
    logic               r_src_sw, r_dst_sw;
    logic [7:0]         r_to_port, r_out;
    logic [PORT_AW-1:0] r_port, r_dp;
    logic [BLK_AW-1:0]  r_blk;
    logic [3:0]         r_mtu;
    logic [4:0]         r_rate;
    logic [6:0]         r_hops;

    logic               r_ov;
    t_result            r_res;

    logic [PORT_AW-1:0] port_addr;
    logic [IDX_W-1:0]   lim_now, lim_cur;
    logic               hit;
    t_item              it;

    assign it = i_item;

    function automatic logic [IDX_W-1:0] lim_of(input t_tbl tbl, input logic [8:0] p,
                                                input logic [8:0] l, input logic [6:0] s,
                                                input logic [8:0] b);
        logic [IDX_W-1:0] v;
        case (tbl)
            TBL_PORT: v = p;
            TBL_LINK: v = l;
            TBL_TOP:  v = {2'b00, s};
            TBL_BLK:  v = b;
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign lim_now   = lim_of(i_cmd.tbl, r_port_used, r_link_used, r_sw_used, r_blk_used);
    assign lim_cur   = lim_of(r_tbl, r_port_used, r_link_used, r_sw_used, r_blk_used);
    assign port_addr = i_cmd.rd_cur ? r_port : r_idx[PORT_AW-1:0];

    always_comb begin
        case (r_tbl)
            TBL_PORT: hit = (r_rd_port.lid == r_key_lid) &&
                            (!r_rd_port.sw || (!r_key_host && r_key_pn == r_rd_port.num));
            TBL_LINK: hit = (r_rd_link.from_lid == r_key_lid) &&
                            (r_key_host || r_key_pn == r_rd_link.from_port);
            TBL_TOP:  hit = (r_rd_top.lid == r_key_lid);
            TBL_BLK:  hit = (r_rd_blk.lid == r_key_lid) &&
                            (r_rd_blk.num == {6'b0, r_dst[15:6]});
            default:  hit = 1'b0;
        endcase
    end

    assign o_stat.hit         = hit;
    assign o_stat.last        = (IDX_W'(r_idx + 1'b1) == lim_cur);
    assign o_stat.empty       = (lim_now == '0);
    assign o_stat.idx_is_dp   = (r_idx[PORT_AW-1:0] == r_dp);
    assign o_stat.port_is_dp  = (r_port == r_dp);
    assign o_stat.rd_sw       = r_rd_port.sw;
    assign o_stat.top_bad     = (r_dst > r_rd_top.top);
    assign o_stat.byte_nopath = (r_rd_byte == NO_PATH_BYTE);
    assign o_stat.hop_over    = (r_hops > 7'(HOP_LIMIT));
    assign o_stat.src_sw      = r_src_sw;
    assign o_stat.out_busy    = r_ov && i_out_stall;

    assign o_valid  = r_ov;
    assign o_result = r_res;

    // table loads and registered reads
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            case (t_action'(it.action))
                ACT_PORT_LOAD: begin
                    if (int'(it.slot) < PORT_ENTRIES) begin
                        port_mem[it.slot[PORT_AW-1:0]] <= '{it.first_lid, it.first_port,
                            it.first_is_switch, it.link_rate, it.port_mtu};
                    end
                end
                ACT_LINK_LOAD: begin
                    if (int'(it.slot) < LINK_ENTRIES) begin
                        link_mem[it.slot[LINK_AW-1:0]] <= '{it.first_lid, it.first_port,
                            it.second_lid, it.second_port};
                    end
                end
                ACT_TOP_LOAD: begin
                    if (int'(it.slot) < SWITCH_ENTRIES) begin
                        top_mem[it.slot[TOP_AW-1:0]] <= '{it.first_lid, it.second_lid};
                    end
                end
                ACT_BLOCK_LOAD: begin
                    if (int'(it.slot) < BLOCK_ENTRIES) begin
                        blk_mem[it.slot[BLK_AW-1:0]] <= '{it.first_lid, it.second_lid};
                    end
                end
                ACT_BYTE_LOAD: begin
                    if (int'(it.slot) < BLOCK_ENTRIES && int'(it.first_port) < BLOCK_BYTES) begin
                        byte_mem[{it.slot[BLK_AW-1:0], it.first_port[POS_W-1:0]}]
                            <= it.second_port;
                    end
                end
                default: ;
            endcase
        end
        r_rd_port <= port_mem[port_addr];
        r_rd_link <= link_mem[r_idx[LINK_AW-1:0]];
        r_rd_top  <= top_mem[r_idx[TOP_AW-1:0]];
        r_rd_blk  <= blk_mem[r_idx[BLK_AW-1:0]];
        r_rd_byte <= byte_mem[{r_blk, r_dst[POS_W-1:0]}];
    end

    // walk payload registers
    always_ff @(posedge i_clk) begin
        if (i_take && t_action'(it.action) == ACT_QUERY) begin
            r_src    <= it.first_lid;
            r_src_sw <= it.first_is_switch;
            r_dst    <= it.second_lid;
            r_dst_sw <= it.second_is_switch;
        end
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
            r_tbl <= i_cmd.tbl;
            case (i_cmd.key)
                KEY_SRC: begin
                    r_key_lid <= r_src; r_key_pn <= 8'd0; r_key_host <= !r_src_sw;
                end
                KEY_DST: begin
                    r_key_lid <= r_dst; r_key_pn <= 8'd0; r_key_host <= !r_dst_sw;
                end
                KEY_FWD: begin
                    r_key_lid <= r_fwd_lid; r_key_pn <= r_out; r_key_host <= 1'b0;
                end
                KEY_CUR: begin
                    r_key_lid  <= r_rd_port.lid;
                    r_key_pn   <= r_rd_port.num;
                    r_key_host <= !r_rd_port.sw;
                end
                KEY_TO: begin
                    r_key_lid <= r_to_lid; r_key_pn <= r_to_port; r_key_host <= 1'b0;
                end
                default: begin
                    r_key_lid <= r_src; r_key_pn <= 8'd0; r_key_host <= 1'b0;
                end
            endcase
        end else if (i_cmd.scan_inc) begin
            r_idx <= IDX_W'(r_idx + 1'b1);
        end
        if (i_cmd.cap_sp) begin
            r_port <= r_idx[PORT_AW-1:0];
            r_mtu  <= r_rd_port.mtu;
            r_rate <= r_rd_port.rate;
            r_hops <= 7'd0;
        end
        if (i_cmd.cap_dp)   r_dp   <= r_idx[PORT_AW-1:0];
        if (i_cmd.cap_port) r_port <= r_idx[PORT_AW-1:0];
        if (i_cmd.merge) begin
            if (r_rd_port.mtu < r_mtu) r_mtu <= r_rd_port.mtu;
            if (rate_rank(r_rate) > rate_rank(r_rd_port.rate)) r_rate <= r_rd_port.rate;
        end
        if (i_cmd.inc_hop) r_hops <= 7'(r_hops + 1'b1);
        if (i_cmd.cap_link) begin
            r_to_lid  <= r_rd_link.to_lid;
            r_to_port <= r_rd_link.to_port;
        end
        if (i_cmd.cap_blk) r_blk     <= r_idx[BLK_AW-1:0];
        if (i_cmd.cap_out) r_out     <= r_rd_byte;
        if (i_cmd.fwd_src) r_fwd_lid <= r_src;
        if (i_cmd.fwd_to)  r_fwd_lid <= r_to_lid;
        if (i_cmd.finish) begin
            r_res.status <= i_cmd.fin_status;
            if (i_cmd.fin_status == ST_OK) begin
                r_res.path_mtu  <= r_mtu;
                r_res.path_rate <= r_rate;
                r_res.hop_count <= r_hops;
            end else begin
                r_res.path_mtu  <= 4'd0;
                r_res.path_rate <= 5'd0;
                r_res.hop_count <= 7'd0;
            end
        end
    end

    // control: entry counts and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_used <= 9'd0;
            r_link_used <= 9'd0;
            r_sw_used   <= 7'd0;
            r_blk_used  <= 9'd0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PORT_USED: r_port_used <= (int'(i_cfg_data) > PORT_ENTRIES) ?
                        9'(PORT_ENTRIES) : i_cfg_data;
                    CFG_LINK_USED: r_link_used <= (int'(i_cfg_data) > LINK_ENTRIES) ?
                        9'(LINK_ENTRIES) : i_cfg_data;
                    CFG_SWITCH_USED: r_sw_used <= (int'(i_cfg_data[6:0]) > SWITCH_ENTRIES) ?
                        7'(SWITCH_ENTRIES) : i_cfg_data[6:0];
                    CFG_BLOCK_USED: r_blk_used <= (int'(i_cfg_data) > BLOCK_ENTRIES) ?
                        9'(BLOCK_ENTRIES) : i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

/* rtl/fpw_ctrl.sv */
// ---------------------------------------------------------------------------
// Path record walker controller
// Sequences table scans for one query and hands the outcome to the datapath.
// ---------------------------------------------------------------------------
module fpw_ctrl
    import fpw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_item i_item,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_stall
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SCAN_RD, S_SCAN_CMP, S_FWD, S_BYTE_RD, S_BYTE,
        S_OUT, S_HOPCHK, S_CUR_RD, S_CUR, S_TO, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        STEP_SP, STEP_DP, STEP_TOP, STEP_BLK, STEP_OUT, STEP_LINK, STEP_TO
    } t_step;

    t_state  r_state, n_state;
    t_step   r_step, n_step;
    logic    r_mid, n_mid;
    t_status r_fin, n_fin;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_mid   = r_mid;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.tbl        = TBL_PORT;
        o_cmd.key        = KEY_SRC;
        o_cmd.fin_status = r_fin;
        case (r_state)
            S_IDLE: begin
                if (i_take && t_action'(i_item.action) == ACT_QUERY) begin
                    n_state = S_START;
                    n_mid   = 1'b0;
                end
            end
            S_START: begin
                o_cmd.scan_clr = 1'b1;
                n_step = STEP_SP;
                n_fin  = ST_ERR;
                n_state = i_stat.empty ? S_FIN : S_SCAN_RD;
            end
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (i_stat.hit) begin
                    case (r_step)
                        STEP_SP: begin
                            o_cmd.cap_sp   = 1'b1;
                            o_cmd.scan_clr = 1'b1;
                            o_cmd.key      = KEY_DST;
                            n_step  = STEP_DP;
                            n_state = S_SCAN_RD;
                        end
                        STEP_DP: begin
                            o_cmd.cap_dp = 1'b1;
                            if (i_stat.src_sw) begin
                                o_cmd.fwd_src = 1'b1;
                                n_state = S_FWD;
                            end else begin
                                n_state = S_CUR_RD;
                            end
                        end
                        STEP_TOP: begin
                            if (i_stat.top_bad) begin
                                n_fin   = ST_ERR;
                                n_state = S_FIN;
                            end else begin
                                o_cmd.scan_clr = 1'b1;
                                o_cmd.tbl      = TBL_BLK;
                                o_cmd.key      = KEY_FWD;
                                n_step = STEP_BLK;
                                if (i_stat.empty) begin
                                    n_fin   = ST_NOPATH;
                                    n_state = S_FIN;
                                end else begin
                                    n_state = S_SCAN_RD;
                                end
                            end
                        end
                        STEP_BLK: begin
                            o_cmd.cap_blk = 1'b1;
                            n_state = S_BYTE_RD;
                        end
                        STEP_OUT: begin
                            o_cmd.cap_port = 1'b1;
                            if (r_mid) begin
                                o_cmd.merge   = 1'b1;
                                o_cmd.inc_hop = 1'b1;
                                n_state = S_HOPCHK;
                            end else begin
                                n_state = S_CUR_RD;
                            end
                        end
                        STEP_LINK: begin
                            o_cmd.cap_link = 1'b1;
                            n_state = S_TO;
                        end
                        STEP_TO: begin
                            o_cmd.cap_port = 1'b1;
                            if (i_stat.idx_is_dp) begin
                                n_state = S_CUR_RD;
                            end else if (!i_stat.rd_sw) begin
                                // host port in the middle of the path
                                n_fin   = ST_ERR;
                                n_state = S_FIN;
                            end else begin
                                o_cmd.merge  = 1'b1;
                                o_cmd.fwd_to = 1'b1;
                                n_mid   = 1'b1;
                                n_state = S_FWD;
                            end
                        end
                        default: begin
                            n_fin   = ST_ERR;
                            n_state = S_FIN;
                        end
                    endcase
                end else if (i_stat.last) begin
                    // a missing block header reads as no path
                    n_fin   = (r_step == STEP_BLK) ? ST_NOPATH : ST_ERR;
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_FWD: begin
                o_cmd.scan_clr = 1'b1;
                o_cmd.tbl      = TBL_TOP;
                o_cmd.key      = KEY_FWD;
                n_step = STEP_TOP;
                n_fin  = ST_ERR;
                n_state = i_stat.empty ? S_FIN : S_SCAN_RD;
            end
            S_BYTE_RD: n_state = S_BYTE;
            S_BYTE: begin
                o_cmd.cap_out = 1'b1;
                if (i_stat.byte_nopath) begin
                    n_fin   = ST_NOPATH;
                    n_state = S_FIN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.scan_clr = 1'b1;
                o_cmd.key      = KEY_FWD;
                n_step = STEP_OUT;
                n_fin  = ST_ERR;
                n_state = i_stat.empty ? S_FIN : S_SCAN_RD;
            end
            S_HOPCHK: begin
                if (i_stat.hop_over) begin
                    n_fin   = ST_ERR;
                    n_state = S_FIN;
                end else begin
                    n_state = S_CUR_RD;
                end
            end
            S_CUR_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state = S_CUR;
            end
            S_CUR: begin
                if (i_stat.port_is_dp) begin
                    o_cmd.merge = 1'b1;
                    n_fin   = ST_OK;
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.tbl      = TBL_LINK;
                    o_cmd.key      = KEY_CUR;
                    n_step = STEP_LINK;
                    n_fin  = ST_ERR;
                    n_state = i_stat.empty ? S_FIN : S_SCAN_RD;
                end
            end
            S_TO: begin
                o_cmd.scan_clr = 1'b1;
                o_cmd.key      = KEY_TO;
                n_step = STEP_TO;
                n_fin  = ST_ERR;
                n_state = i_stat.empty ? S_FIN : S_SCAN_RD;
            end
            S_FIN: begin
                // hold until the result register is free
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_SP;
            r_mid   <= 1'b0;
            r_fin   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_mid   <= n_mid;
            r_fin   <= n_fin;
        end
    end

endmodule

/* rtl/fabric_path_record_walker.sv */
// A load writes its table entry when taken. A query scans the tables one entry at a time,
// and each hop scans link, port, switch top, block and port tables; a query walks up to
// 64 hops. One query is in flight at a time: o_stall holds off new items while it runs.
// Reset (synchronous, active low) clears the entry counts, controller and result valid;
// table contents are undefined until loaded.
// ---------------------------------------------------------------------------
// Fabric path record walker
// Loads subnet tables and answers path queries with MTU, rate and hop count.
// ---------------------------------------------------------------------------
`include "fabric_path_record_walker_macros.svh"

module fabric_path_record_walker
    import fpw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  take;

    assign take        = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    fpw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    fpw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    `FPW_CHECK_IMPL(a_ok_hops, o_valid && o_result.status == ST_OK, o_result.hop_count <= 7'(HOP_LIMIT))
    `FPW_CHECK_IMPL(a_fail_zero, o_valid && o_result.status != ST_OK, o_result.path_mtu == 4'd0 && o_result.path_rate == 5'd0 && o_result.hop_count == 7'd0)
    `FPW_CHECK_IMPL(a_finish_free, cmd.finish, !stat.out_busy)
    `FPW_CHECK_NEXT(a_finish_valid, cmd.finish, o_valid)

endmodule
